>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use names a label, an antecedent
// and a consequent; the enclosing module must provide clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SFM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfm: same-cycle assertion violated");

// The consequent holds in the cycle after the antecedent.
`define SFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfm: next-cycle assertion violated");

`endif

>>> hw/rtl/sfm_pkg.sv
package sfm_pkg;

  localparam int PATTERN_MAX_DEF    = 32;
  localparam int POSITION_WIDTH_DEF = 16;

  localparam int MODE_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_PENDING  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] byte_value;
    logic              is_last;
  } sfm_item_t;

endpackage

>>> hw/rtl/sfm_in_if.sv
interface sfm_in_if;
  import sfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] byte_value;
  logic              is_last;

  modport source (output valid, output mode, output byte_value, output is_last, input ready);
  modport sink   (input valid, input mode, input byte_value, input is_last, output ready);
endinterface

>>> hw/rtl/sfm_out_if.sv
interface sfm_out_if #(
  parameter int POSITION_WIDTH = sfm_pkg::POSITION_WIDTH_DEF
);
  import sfm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [POSITION_WIDTH-1:0] match_start;

  modport source (output valid, output status, output match_start, input ready);
  modport sink   (input valid, input status, input match_start, output ready);
endinterface

>>> hw/rtl/sfm_in_stage.sv
module sfm_in_stage (
  input  logic              clk,
  input  logic              rst,
  sfm_in_if.sink            req,
  output logic              s_valid,
  input  logic              s_ready,
  output sfm_pkg::sfm_item_t s_item
);
  import sfm_pkg::*;

  logic accept;

  // The register frees up whenever its item moves on, so a new item can
  // enter in the same cycle.
  assign req.ready = !s_valid || s_ready;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (accept) begin
      s_valid <= 1'b1;
    end else if (s_ready) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item.mode       <= req.mode;
      s_item.byte_value <= req.byte_value;
      s_item.is_last    <= req.is_last;
    end
  end
endmodule

>>> hw/rtl/sfm_match.sv
`include "assert_macros.svh"

module sfm_match #(
  parameter int PATTERN_MAX    = sfm_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_WIDTH = sfm_pkg::POSITION_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  sfm_pkg::sfm_item_t s_item,
  sfm_out_if.source          rsp
);
  import sfm_pkg::*;

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int CW = (POSITION_WIDTH > LW) ? POSITION_WIDTH : LW;

  // The pattern is held newest byte first, so that entry j lines up with
  // window entry j; mask marks the entries that belong to the pattern.
  logic [LW-1:0]             plen;
  logic [PATTERN_MAX-1:0]    mask;
  logic [BYTE_W-1:0]         pat [PATTERN_MAX];
  logic [BYTE_W-1:0]         win [PATTERN_MAX];
  logic [POSITION_WIDTH-1:0] pos;
  logic                      done;

  logic                      out_valid;
  logic [STATUS_W-1:0]       out_status;
  logic [POSITION_WIDTH-1:0] out_start;

  logic                      load;
  logic                      full;
  logic                      do_clear;
  logic                      do_append;
  logic                      do_text;
  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [PATTERN_MAX-1:0]    eq;
  logic                      hit;
  logic                      enough;
  logic [STATUS_W-1:0]       status_next;
  logic [POSITION_WIDTH-1:0] start_next;

  assign s_ready = !out_valid || rsp.ready;
  assign load    = s_valid && s_ready;
  assign full    = (plen == LW'(PATTERN_MAX));

  assign do_clear  = load && (s_item.mode == MODE_CLEAR);
  assign do_append = load && (s_item.mode == MODE_APPEND) && !full;
  assign do_text   = load && (s_item.mode == MODE_TEXT) && !done;

  assign pos_inc = (pos == '1) ? pos : pos + POSITION_WIDTH'(1);

  // Compare the window as it will be after the new byte shifts in.
  always_comb begin
    eq[0] = (s_item.byte_value == pat[0]);
    for (int j = 1; j < PATTERN_MAX; j++) begin
      eq[j] = (win[j-1] == pat[j]);
    end
  end

  assign hit    = &(eq | ~mask);
  assign enough = (CW'(pos_inc) >= CW'(plen));

  always_comb begin
    status_next = STATUS_PENDING;
    start_next  = '0;
    priority if ((s_item.mode == MODE_APPEND) && full) begin
      status_next = STATUS_OVERFLOW;
    end else if ((s_item.mode == MODE_TEXT) && !done) begin
      priority if (plen == '0) begin
        status_next = STATUS_MATCH;
      end else if (enough && hit) begin
        status_next = STATUS_MATCH;
        start_next  = POSITION_WIDTH'(CW'(pos_inc) - CW'(plen));
      end else if (s_item.is_last) begin
        status_next = STATUS_NO_MATCH;
      end else begin
        status_next = STATUS_PENDING;
      end
    end else begin
      status_next = STATUS_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= '0;
      mask      <= '0;
      pos       <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (do_clear) begin
        plen <= '0;
        mask <= '0;
        pos  <= '0;
        done <= 1'b0;
      end else if (do_append) begin
        plen <= plen + LW'(1);
        mask <= (mask << 1) | PATTERN_MAX'(1);
        pos  <= '0;
        done <= 1'b0;
      end else if (do_text) begin
        pos <= pos_inc;
        if (status_next != STATUS_PENDING) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status_next;
      out_start  <= start_next;
    end
    if (do_append) begin
      for (int j = PATTERN_MAX - 1; j > 0; j--) begin
        pat[j] <= pat[j-1];
      end
      pat[0] <= s_item.byte_value;
    end
    if (do_text) begin
      for (int j = PATTERN_MAX - 1; j > 0; j--) begin
        win[j] <= win[j-1];
      end
      win[0] <= s_item.byte_value;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.match_start = out_start;

  `SFM_ASSERT_IMPL(a_len_bound, 1'b1, plen <= LW'(PATTERN_MAX))
  `SFM_ASSERT_IMPL(a_mask_len, 1'b1, $countones(mask) == int'(plen))
  `SFM_ASSERT_NEXT(a_match_done, load && (status_next == STATUS_MATCH), done)
  `SFM_ASSERT_NEXT(a_done_quiet, load && done && (s_item.mode == MODE_TEXT), rsp.status == STATUS_PENDING)
endmodule

>>> hw/rtl/substring_first_match.sv
// Substring search that reports the first occurrence of a pattern in a byte
// stream. Transactions arrive on req (mode, byte_value, is_last): a clear
// empties the pattern and restarts the search, an append adds one pattern
// byte (status overflow once PATTERN_MAX bytes are held), and a text byte
// advances the search. Every request transaction yields exactly one
// transaction on rsp (status, match_start). The search finishes with a match
// start position or, on the byte marked last, with a no-match status; later
// text bytes report pending until a clear or an accepted append restarts it.
// A transaction passes through the input register, then through the window
// compare into the result register. Throughput is one transaction per cycle
// while rsp is ready, set by a single parallel compare of the whole window
// against the pattern. Synchronous reset empties the pattern, clears the
// position and the done flag, and drops both pipeline valids. When rsp
// stalls, the result register holds and the input register can still take
// one more transaction before req.ready falls.
module substring_first_match #(
  parameter int PATTERN_MAX    = sfm_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_WIDTH = sfm_pkg::POSITION_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sfm_in_if.sink    req,
  sfm_out_if.source rsp
);
  import sfm_pkg::*;

  // Handoff between the input register and the compare stage.
  logic      s_valid;
  logic      s_ready;
  sfm_item_t s_item;

  sfm_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item)
  );

  // Pattern and window storage, the compare, and the result register.
  sfm_match #(
    .PATTERN_MAX    (PATTERN_MAX),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_match (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .rsp     (rsp)
  );
endmodule

>>> dv/substring_first_match_test.sv
`timescale 1ns / 1ps

// Self-checking test of the first-occurrence substring search.
// One initial block runs the named tests in order. Every test feeds
// transactions through send_item, which waits for the handshake and then
// asks the search predictor for the expected result. A separate process
// compares each result transaction with the oldest entry of the expected
// result queue. Both the request side and the response side idle at random,
// except during a quiet stretch in the middle of the random test.
module substring_first_match_test;
  import sfm_pkg::*;

  localparam int PAT_MAX      = PATTERN_MAX_DEF;
  localparam int POS_W        = POSITION_WIDTH_DEF;
  localparam int LEN_W        = $clog2(PAT_MAX + 1);
  localparam int IDLE_PCT     = 22;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_TEXT    = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 40_000;

  // The package names only three modes; the fourth code must be ignored.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    match_start;
  } search_result_t;

  logic clk;
  logic rst;

  sfm_in_if                           req_if ();
  sfm_out_if #(.POSITION_WIDTH(POS_W)) rsp_if ();

  substring_first_match #(
    .PATTERN_MAX   (PAT_MAX),
    .POSITION_WIDTH(POS_W)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  // Predictor state: a private copy of the pattern, the sliding text window
  // (entry 0 is the newest byte), the saturating position and the done flag.
  logic [BYTE_W-1:0] model_pattern [PAT_MAX];
  logic [LEN_W-1:0]  model_pat_len;
  logic [BYTE_W-1:0] model_window  [PAT_MAX];
  logic [POS_W-1:0]  model_text_pos;
  logic              model_done;

  search_result_t expected_q [$];
  search_result_t oldest;
  int             error_count = 0;
  int             items_sent  = 0;
  int             cycle_count = 0;
  bit             quiet_phase = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The cycle counter is the only timeout. It never stops a correct run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("substring_first_match regression: fail");
    $finish;
  end

  // Response back-pressure. Ready drops in about a fifth of the cycles unless
  // the quiet stretch is running.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= quiet_phase || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Result checker. Every transaction on rsp must line up with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result status %0d with nothing expected", rsp_if.status));
      end else begin
        oldest = expected_q.pop_front();
        if (rsp_if.status !== oldest.status)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, oldest.status));
        if (rsp_if.match_start !== oldest.match_start)
          report_mismatch($sformatf("match_start %0d, expected %0d",
                                    rsp_if.match_start, oldest.match_start));
      end
    end
  end

  // Both a clear and a stored pattern byte start the text search over.
  function automatic void restart_model_search();
    for (int i = 0; i < PAT_MAX; i++) model_window[i] = '0;
    model_text_pos = '0;
    model_done     = 1'b0;
  endfunction

  // Search predictor: advances the private state by one request and returns
  // the result it must produce.
  function automatic search_result_t predict_search(input sfm_item_t it);
    search_result_t r;
    bit             hit;
    r.status      = STATUS_PENDING;
    r.match_start = '0;
    case (it.mode)
      MODE_CLEAR: begin
        model_pat_len = '0;
        restart_model_search();
      end
      MODE_APPEND: begin
        if (model_pat_len >= PAT_MAX) begin
          // A full pattern refuses the byte and keeps the search untouched.
          r.status = STATUS_OVERFLOW;
        end else begin
          model_pattern[model_pat_len] = it.byte_value;
          model_pat_len++;
          restart_model_search();
        end
      end
      MODE_TEXT: begin
        if (!model_done) begin
          for (int i = PAT_MAX - 1; i > 0; i--) model_window[i] = model_window[i-1];
          model_window[0] = it.byte_value;
          if (model_text_pos != '1) model_text_pos++;
          hit = 1'b0;
          if (model_pat_len == 0) begin
            // An empty pattern matches at the very start of the text.
            hit = 1'b1;
          end else if (model_text_pos >= model_pat_len) begin
            hit = 1'b1;
            for (int i = 0; i < model_pat_len; i++)
              if (model_window[model_pat_len - 1 - i] != model_pattern[i]) hit = 1'b0;
            if (hit) r.match_start = model_text_pos - model_pat_len;
          end
          // A match on the last byte wins over the no-match status.
          if (hit) begin
            r.status   = STATUS_MATCH;
            model_done = 1'b1;
          end else if (it.is_last) begin
            r.status   = STATUS_NO_MATCH;
            model_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sfm_item_t make_item(input logic [MODE_W-1:0] mode,
                                          input logic [BYTE_W-1:0] value,
                                          input logic              last);
    sfm_item_t it;
    it.mode       = mode;
    it.byte_value = value;
    it.is_last    = last;
    return it;
  endfunction

  // Sends one request transaction. Random idle cycles come first, so gaps
  // land between any two requests; valid stays high across back-to-back
  // transactions.
  task automatic send_item(input sfm_item_t it);
    while (!quiet_phase && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= it.mode;
    req_if.byte_value <= it.byte_value;
    req_if.is_last    <= it.is_last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_q.push_back(predict_search(it));
    items_sent++;
  endtask

  // With no pattern the first text byte matches at position 0, and the
  // search then ignores text, including a byte marked last.
  task automatic test_empty_pattern();
    send_item(make_item(MODE_CLEAR, 8'hFF, 1'b1));
    send_item(make_item(MODE_TEXT, 8'h00, 1'b0));
    send_item(make_item(MODE_TEXT, 8'hFF, 1'b1));
  endtask

  // Two-byte pattern found one byte into the text; the byte after the match
  // is ignored.
  task automatic test_first_match();
    send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
    send_item(make_item(MODE_APPEND, 8'hFF, 1'b0));
    send_item(make_item(MODE_APPEND, 8'h00, 1'b1));
    send_item(make_item(MODE_TEXT, 8'h00, 1'b0));
    send_item(make_item(MODE_TEXT, 8'hFF, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h00, 1'b0));
    send_item(make_item(MODE_TEXT, 8'hFF, 1'b1));
  endtask

  // Appending restarts the search. Too little text before the last byte
  // gives no match; a match on the last byte itself reports the match.
  task automatic test_end_of_text();
    send_item(make_item(MODE_APPEND, 8'h80, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h7F, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h01, 1'b1));
    send_item(make_item(MODE_CLEAR, 8'h55, 1'b0));
    send_item(make_item(MODE_APPEND, 8'h41, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h41, 1'b1));
  endtask

  // The unused mode code changes nothing, whatever the byte and flag say.
  task automatic test_unused_mode();
    send_item(make_item(MODE_UNUSED, 8'hFF, 1'b1));
    send_item(make_item(MODE_UNUSED, 8'h00, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h41, 1'b0));
  endtask

  // Fill the pattern, push one byte too many, then prove the full pattern is
  // intact by matching it against text at position 0.
  task automatic test_pattern_overflow();
    send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
    for (int i = 0; i < PAT_MAX; i++)
      send_item(make_item(MODE_APPEND, BYTE_W'(i * 8 + 1), 1'b0));
    send_item(make_item(MODE_APPEND, 8'h33, 1'b1));
    for (int i = 0; i < PAT_MAX; i++)
      send_item(make_item(MODE_TEXT, BYTE_W'(i * 8 + 1), i == PAT_MAX - 1));
  endtask

  // A long run of text before the pattern shows up, so the start lies far
  // from the beginning of the text.
  task automatic test_long_text();
    send_item(make_item(MODE_CLEAR, 8'h00, 1'b0));
    send_item(make_item(MODE_APPEND, 8'h5A, 1'b0));
    send_item(make_item(MODE_APPEND, 8'hA5, 1'b0));
    for (int k = 0; k < LONG_TEXT; k++)
      send_item(make_item(MODE_TEXT, 8'h00, 1'b0));
    send_item(make_item(MODE_TEXT, 8'h5A, 1'b0));
    send_item(make_item(MODE_TEXT, 8'hA5, 1'b1));
  endtask

  // Mostly well-formed searches: clear, a short pattern over a small
  // alphabet, then text from the same alphabet, often with the pattern
  // planted in it and usually ending in a byte marked last. The rest is
  // noise with every mode, byte and flag value, which also breaks searches
  // in the middle. The middle third of the run has no idling on either side.
  task automatic test_random_sequences();
    int                stop_at;
    int                plen;
    int                tlen;
    int                asz;
    int                slot;
    int                n_noise;
    bit                mark_last;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] pat [PAT_MAX];
    logic [BYTE_W-1:0] text_q [$];
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      quiet_phase = (items_sent > stop_at - 2 * RANDOM_ITEMS / 3) &&
                    (items_sent < stop_at - RANDOM_ITEMS / 3);
      if ($urandom_range(99) < 80) begin
        base = BYTE_W'($urandom_range(255));
        asz  = int'($urandom_range(1, 4));
        plen = ($urandom_range(19) == 0) ? PAT_MAX : int'($urandom_range(1, 6));
        if ($urandom_range(19) == 0) plen = 0;
        send_item(make_item(MODE_CLEAR, BYTE_W'($urandom_range(255)),
                            1'($urandom_range(1))));
        for (int j = 0; j < plen; j++) begin
          pat[j] = BYTE_W'(base + $urandom_range(asz - 1));
          send_item(make_item(MODE_APPEND, pat[j], 1'($urandom_range(1))));
        end
        if (plen == PAT_MAX)
          send_item(make_item(MODE_APPEND, BYTE_W'($urandom_range(255)),
                              1'($urandom_range(1))));
        tlen = int'($urandom_range(1, plen + 24));
        text_q.delete();
        for (int j = 0; j < tlen; j++)
          text_q.push_back(BYTE_W'(base + $urandom_range(asz - 1)));
        if (tlen >= plen && $urandom_range(1)) begin
          slot = int'($urandom_range(tlen - plen));
          for (int j = 0; j < plen; j++) text_q[slot + j] = pat[j];
        end
        mark_last = ($urandom_range(9) != 0);
        for (int j = 0; j < tlen; j++)
          send_item(make_item(MODE_TEXT, text_q[j], mark_last && (j == tlen - 1)));
      end else begin
        n_noise = int'($urandom_range(1, 8));
        for (int j = 0; j < n_noise; j++)
          send_item(make_item(MODE_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
                              1'($urandom_range(1))));
      end
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.mode       <= MODE_CLEAR;
    req_if.byte_value <= '0;
    req_if.is_last    <= 1'b0;
    model_pat_len     = '0;
    for (int i = 0; i < PAT_MAX; i++) model_pattern[i] = '0;
    restart_model_search();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_first_match();
    test_end_of_text();
    test_unused_mode();
    test_pattern_overflow();
    test_random_sequences();
    test_long_text();

    // Stop requesting, let the pipeline drain, then give a few more cycles
    // so that any stray result would still be seen by the checker.
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("substring_first_match regression: pass");
    end else begin
      $display("substring_first_match regression: fail");
    end
    $finish;
  end

endmodule

>>> substring_first_match.f
+incdir+hw/rtl
hw/rtl/sfm_pkg.sv
hw/rtl/sfm_in_if.sv
hw/rtl/sfm_out_if.sv
hw/rtl/sfm_in_stage.sv
hw/rtl/sfm_match.sv
hw/rtl/substring_first_match.sv
dv/substring_first_match_test.sv
